// ===== hw/rtl/tbm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the tap-tempo meter.
// Used by tbm_div, tbm_dp, tbm_ctrl and tap_tempo_bpm_meter; depends on nothing.
package tbm_pkg;

  // Window storage
  localparam int MAX_TAPS = 16;
  localparam int SLOT_W   = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);

  // Field widths
  localparam int TS_W  = 64;
  localparam int TPS_W = 32;
  localparam int RAS_W = 8;
  localparam int TTA_W = 5;
  localparam int BPM_W = 24;

  // 60 s * 256 (Q8) per minute
  localparam int Q8_MIN_W = 14;
  localparam logic [Q8_MIN_W-1:0] Q8_MINUTE = Q8_MIN_W'(15360);

  localparam int TMO_W    = RAS_W + TPS_W;
  localparam int SCALED_W = TPS_W + Q8_MIN_W;
  localparam int NUM_W    = SCALED_W + SLOT_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic [BPM_W-1:0] TEMPO_MAX = {BPM_W{1'b1}};

  // Configuration register map
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TTA = 2'd2;

  localparam logic [TPS_W-1:0] TPS_RST = TPS_W'(10000000);
  localparam logic [RAS_W-1:0] RAS_RST = RAS_W'(3);
  localparam logic [TTA_W-1:0] TTA_RST = TTA_W'(8);

  // Input operation codes
  localparam logic OP_TAP   = 1'b0;
  localparam logic OP_RESET = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // latch input word, read newest slot
    logic check;       // reset/timeout decision, ring update
    logic read_old;    // read oldest slot
    logic start_div;   // launch the divider
    logic set_max;     // zero span: saturate tempo
    logic load_tempo;  // take the divider quotient
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic more;        // window holds two or more taps after the update
    logic span_zero;   // newest equals oldest
    logic div_done;    // quotient ready
  } dp_stat_t;

endpackage

// ===== hw/rtl/tbm_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on tbm_pkg.
module tbm_div
  import tbm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [TS_W-1:0]  den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic [TS_W-1:0]      rem_r, rem_nxt;
  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [TS_W-1:0]      den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [TS_W:0]        trial;
  logic                 ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    quo_nxt = {quo_r[NUM_W-2:0], ge};
    if (ge) begin
      rem_nxt = TS_W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[TS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hw/rtl/tbm_dp.sv =====
`timescale 1ns / 1ps
// Datapath: tap ring memory, window pointers, timeout and tempo arithmetic.
// Depends on tbm_pkg and tbm_div.
module tbm_dp
  import tbm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_cmd_t        cmd,
  output dp_stat_t         stat,
  input  logic             cfg_clr,
  input  logic [TPS_W-1:0] tps,
  input  logic [RAS_W-1:0] ras,
  input  logic [TTA_W-1:0] tta,
  input  logic             in_op,
  input  logic [TS_W-1:0]  in_ts,
  output logic [BPM_W-1:0] tempo,
  output logic [CNT_W-1:0] taps,
  output logic             cleared
);

  logic [TS_W-1:0]     ring_mem [MAX_TAPS];
  logic [TS_W-1:0]     rd_r;
  logic [SLOT_W-1:0]   rd_addr;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;

  logic [TS_W-1:0]     ts_r;
  logic                op_r;
  logic [TMO_W-1:0]    timeout_r;
  logic [SCALED_W-1:0] scaled_r;
  logic [NUM_W-1:0]    num_r;
  logic [SLOT_W-1:0]   oldest_r, oldest_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [BPM_W-1:0]    tempo_r;
  logic                cleared_r;

  logic [CNT_W-1:0]    win;
  logic                full;
  logic [CNT_W-1:0]    cnt_mid;
  logic                timed_out;
  logic                drop;
  logic [NUM_W-1:0]    quo;
  logic                div_done;

  // Clamp window size to 1..MAX_TAPS
  always_comb begin
    if (tta == '0) begin
      win = CNT_W'(1);
    end else if (CNT_W'(tta) > CNT_W'(MAX_TAPS)) begin
      win = CNT_W'(MAX_TAPS);
    end else begin
      win = CNT_W'(tta);
    end
  end

  // rd_r holds the newest tap during the check
  assign timed_out = (count_r != '0) && ((ts_r - rd_r) > TS_W'(timeout_r));
  assign drop      = (op_r == OP_RESET) || timed_out;

  always_comb begin
    full       = (count_r >= win);
    oldest_nxt = full ? oldest_r + 1'b1 : oldest_r;
    cnt_mid    = full ? count_r - 1'b1 : count_r;
    count_nxt  = cnt_mid + 1'b1;
    wr_addr    = oldest_nxt + cnt_mid[SLOT_W-1:0];
    wr_en      = cmd.check && !drop && !cfg_clr;
    rd_addr    = cmd.read_old ? oldest_r : oldest_r + SLOT_W'(count_r - 1'b1);
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= ts_r;
    end
    if (cmd.accept || cmd.read_old) begin
      rd_r <= ring_mem[rd_addr];
    end
  end

  // Per-item operands; payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ts_r      <= in_ts;
      op_r      <= in_op;
      timeout_r <= TMO_W'(ras) * TMO_W'(tps);
      scaled_r  <= SCALED_W'(tps) * SCALED_W'(Q8_MINUTE);
    end
    if (cmd.check) begin
      num_r <= NUM_W'(scaled_r) * NUM_W'(cnt_mid[SLOT_W-1:0]);
    end
  end

  // Window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r  <= '0;
      count_r   <= '0;
      tempo_r   <= '0;
      cleared_r <= 1'b0;
    end else if (cfg_clr) begin
      oldest_r <= '0;
      count_r  <= '0;
      tempo_r  <= '0;
    end else begin
      if (cmd.accept) begin
        cleared_r <= 1'b0;
      end
      if (cmd.check) begin
        if (drop) begin
          oldest_r  <= '0;
          count_r   <= '0;
          tempo_r   <= '0;
          cleared_r <= 1'b1;
        end else begin
          oldest_r <= oldest_nxt;
          count_r  <= count_nxt;
        end
      end
      if (cmd.set_max) begin
        tempo_r <= TEMPO_MAX;
      end
      if (cmd.load_tempo) begin
        tempo_r <= (quo[NUM_W-1:BPM_W] != '0) ? TEMPO_MAX : quo[BPM_W-1:0];
      end
    end
  end

  // rd_r holds the oldest tap once the span is formed
  tbm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start_div),
    .num   (num_r),
    .den   (ts_r - rd_r),
    .done  (div_done),
    .quo   (quo)
  );

  assign stat.more      = !drop && (count_nxt > CNT_W'(1));
  assign stat.span_zero = (ts_r == rd_r);
  assign stat.div_done  = div_done;

  assign tempo   = tempo_r;
  assign taps    = count_r;
  assign cleared = cleared_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TAPS))
    else $error("tap count beyond window storage");

  a_cfg_clear : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clr |=> (count_r == '0) && (tempo_r == '0) && (oldest_r == '0))
    else $error("config write did not clear the window");

  a_more_taps : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.check && stat.more && !cfg_clr) |=> (count_r >= CNT_W'(2)))
    else $error("tempo pass started with fewer than two taps");

  a_drop_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.check && drop && !cfg_clr) |=> (cleared_r && (count_r == '0)))
    else $error("reset or timeout left taps in the window");

endmodule

// ===== hw/rtl/tbm_ctrl.sv =====
`timescale 1ns / 1ps
// Controller FSM: sequences accept, check, span read, divide and emit.
// Depends on tbm_pkg.
module tbm_ctrl
  import tbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  input  logic      out_free,
  output ctrl_cmd_t cmd,
  output logic      emit
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_SPAN,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   rdy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    emit      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && rdy_r) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = stat.more ? S_READ : S_EMIT;
      end
      S_READ: begin
        cmd.read_old = 1'b1;
        state_nxt    = S_SPAN;
      end
      S_SPAN: begin
        if (stat.span_zero) begin
          cmd.set_max = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          cmd.start_div = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.load_tempo = 1'b1;
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rdy_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      rdy_r   <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = rdy_r;

endmodule

// ===== hw/rtl/tap_tempo_bpm_meter.sv =====
`timescale 1ns / 1ps
// Tap-tempo meter: sliding-window average of tap intervals as Q8 BPM.
// Reset word, timeout or one held tap: done after the check; else the oldest tap is read and
// the tempo saturates (zero span) or the divider runs 50 restoring steps of one quotient bit each.
// A new word is taken only back in idle; a result the sink has not taken holds the core at emit.
// Reset (rst_n low, synchronous): window empty, tempo 0, registers to defaults; ring
// contents stay undefined and are read only after being written (no clearing pass).
module tap_tempo_bpm_meter
  import tbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // [63:0] timestamp
  input  logic [0:0]            in_tuser,   // [0] operation
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [23:0] bpm_q8, [28:24] taps_held, [31:29] zero
  output logic [0:0]            out_tuser   // [0] window_cleared
);

  // Register file
  logic [TPS_W-1:0]     tps_r;
  logic [RAS_W-1:0]     ras_r;
  logic [TTA_W-1:0]     tta_r;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;
  logic                 cfg_clr;

  // Output register
  logic                 out_valid_r;
  logic [BPM_W-1:0]     out_bpm_r;
  logic [CNT_W-1:0]     out_taps_r;
  logic                 out_clr_r;
  logic                 out_free;

  ctrl_cmd_t            cmd;
  dp_stat_t             stat;
  logic                 emit;
  logic [BPM_W-1:0]     tempo;
  logic [CNT_W-1:0]     taps;
  logic                 cleared;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Any write to a listed register empties the window; others are ignored
  assign cfg_clr = cfg_wr && ((cfg_idx == REG_TPS) || (cfg_idx == REG_RAS) ||
                              (cfg_idx == REG_TTA));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RST;
      ras_r <= RAS_RST;
      tta_r <= TTA_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TPS: tps_r <= cfg_pwdata[TPS_W-1:0];
        REG_RAS: ras_r <= cfg_pwdata[RAS_W-1:0];
        REG_TTA: tta_r <= cfg_pwdata[TTA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TPS: cfg_prdata = CFG_DATA_W'(tps_r);
      REG_RAS: cfg_prdata = CFG_DATA_W'(ras_r);
      REG_TTA: cfg_prdata = CFG_DATA_W'(tta_r);
      default: cfg_prdata = '0;
    endcase
  end

  tbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .out_free (out_free),
    .cmd      (cmd),
    .emit     (emit)
  );

  tbm_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .stat    (stat),
    .cfg_clr (cfg_clr),
    .tps     (tps_r),
    .ras     (ras_r),
    .tta     (tta_r),
    .in_op   (in_tuser[0]),
    .in_ts   (in_tdata),
    .tempo   (tempo),
    .taps    (taps),
    .cleared (cleared)
  );

  // Hold a finished word until the sink takes it; the core may start the next one
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_bpm_r  <= tempo;
      out_taps_r <= taps;
      out_clr_r  <= cleared;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {3'b000, out_taps_r, out_bpm_r};
  assign out_tuser[0] = out_clr_r;

endmodule
